/* hw/rtl/rgbhsl_pkg.sv */
// Shared types and constants of the RGB to HSL pixel converter.
`default_nettype none

package rgbhsl_pkg;

    localparam int CH_W  = 8;
    localparam int OUT_W = 16;
    localparam int SUM_W = CH_W + 1;
    localparam int DIV_W = CH_W + 3;

    localparam logic [SUM_W-1:0] HALF_SUM  = SUM_W'(255);
    localparam logic [SUM_W-1:0] FULL_SUM  = SUM_W'(510);

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

endpackage

`default_nettype wire

/* hw/rtl/rgbhsl_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none

module rgbhsl_div
    import rgbhsl_pkg::*;
#(
    parameter int DEN_W  = 11,
    parameter int QUOT_W = 18
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [DEN_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    output logic      [QUOT_W-1:0] o_quot
);

    logic [DEN_W-1:0]  r_rem  [QUOT_W];
    logic [DEN_W-1:0]  r_den  [QUOT_W];
    logic [QUOT_W-1:0] r_quot [QUOT_W];

    for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
        logic [DEN_W:0]    n_shift;
        logic [DEN_W:0]    n_diff;
        logic [DEN_W:0]    n_dext;
        logic              n_bit;
        logic [DEN_W-1:0]  n_rem;
        logic [DEN_W-1:0]  n_den;
        logic [QUOT_W-1:0] n_quot;

        if (k == 0) begin : g_first
            always_comb begin
                n_den   = i_den;
                n_shift = {1'b0, i_num};
                n_dext  = {1'b0, i_den};
                n_diff  = n_shift - n_dext;
                n_bit   = (n_shift >= n_dext);
                n_rem   = n_bit ? n_diff[DEN_W-1:0] : n_shift[DEN_W-1:0];
                n_quot  = QUOT_W'(n_bit);
            end
        end else begin : g_next
            always_comb begin
                n_den   = r_den[k-1];
                n_shift = {r_rem[k-1], 1'b0};
                n_dext  = {1'b0, r_den[k-1]};
                n_diff  = n_shift - n_dext;
                n_bit   = (n_shift >= n_dext);
                n_rem   = n_bit ? n_diff[DEN_W-1:0] : n_shift[DEN_W-1:0];
                n_quot  = {r_quot[k-1][QUOT_W-2:0], n_bit};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_den[k]  <= n_den;
                r_quot[k] <= n_quot;
            end
        end
    end

    assign o_quot = r_quot[QUOT_W-1];

endmodule

`default_nettype wire

/* hw/rtl/rgb_to_hsl_pixel_core.sv */
// Top level of the RGB to HSL pixel converter.
//
// Input channel: i_valid / o_ready carry one pixel (i_red, i_green, i_blue).
// Output channel: o_valid / i_ready carry hue, saturation and lightness as
// unsigned fractions with FRACTION_BITS fraction bits, sent as 16-bit codes.
// One pixel is taken per cycle and one result leaves per cycle while i_ready is high.
// From input transfer to o_valid a pixel passes the input register (loaded at
// the transfer edge), the min/max stage, the operand stage, FRACTION_BITS + 2
// divider stages (one quotient bit each) and the output register.
// Two dividers run side by side for hue and saturation. Lightness divides by
// a constant, so it is formed in one stage from a repeated bit pattern and
// delayed to line up with the dividers.
// Throughput is one pixel per cycle while the receiver keeps i_ready high.
// When the receiver stalls, one more result lands in a skid register and
// then the whole pipeline holds; o_ready drops only while that skid
// register is full and rises right after the stalled result transfers.
// Synchronous reset empties the pipeline, the output and the skid register.
`default_nettype none

module rgb_to_hsl_pixel_core
    import rgbhsl_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [CH_W-1:0]  i_red,
    input  wire logic [CH_W-1:0]  i_green,
    input  wire logic [CH_W-1:0]  i_blue,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic      [OUT_W-1:0] o_hue,
    output logic      [OUT_W-1:0] o_saturation,
    output logic      [OUT_W-1:0] o_lightness
);

    localparam int QUOT_W = FRACTION_BITS + 2;
    localparam int NSTG   = QUOT_W + 3;
    localparam logic [QUOT_W-1:0] CODE_MAX = QUOT_W'((1 << FRACTION_BITS) - 1);

    logic              w_en;
    logic [NSTG-1:0]   r_v;
    logic [QUOT_W-1:0] r_ach;

    logic [CH_W-1:0]  r_a_red, r_a_green, r_a_blue;
    logic [CH_W-1:0]  r_b_red, r_b_green, r_b_blue, r_b_max, r_b_min;
    t_sector          r_b_sec;
    logic [DIV_W-1:0] r_c_sat_num, r_c_sat_den, r_c_hue_num, r_c_hue_den;
    logic [SUM_W-1:0] r_c_lit_num;
    logic             r_c_ach;

    logic [CH_W-1:0]  n_b_max, n_b_min;
    t_sector          n_b_sec;
    logic [CH_W-1:0]  n_c_d;
    logic [SUM_W-1:0] n_c_sum;
    logic [DIV_W-1:0] n_c_six_d;
    logic [DIV_W-1:0] n_c_hue_num;
    logic [SUM_W-1:0] n_c_sat_den;

    logic [CH_W-1:0]   n_l_rem;
    logic [1:0]        n_l_whole;
    logic [4*CH_W-1:0] n_l_rep;
    logic [QUOT_W-1:0] n_l_q;
    logic [QUOT_W-1:0] r_lit [QUOT_W];

    logic [QUOT_W-1:0] w_q_hue, w_q_sat, w_q_lit;
    logic [QUOT_W-1:0] w_rnd_hue, w_rnd_sat, w_rnd_lit;
    logic [FRACTION_BITS-1:0] w_f_hue, w_f_sat, w_f_lit;
    logic [OUT_W-1:0]  n_hue, n_sat, n_lit;

    logic             r_o_valid, r_s_valid;
    logic [OUT_W-1:0] r_o_hue, r_o_sat, r_o_lit;
    logic [OUT_W-1:0] r_s_hue, r_s_sat, r_s_lit;

    assign w_en    = !r_s_valid;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NSTG-2:0], i_valid};
        end
    end

    always_comb begin
        n_b_max = r_a_red;
        n_b_min = r_a_red;
        if (r_a_green > n_b_max) n_b_max = r_a_green;
        if (r_a_blue > n_b_max)  n_b_max = r_a_blue;
        if (r_a_green < n_b_min) n_b_min = r_a_green;
        if (r_a_blue < n_b_min)  n_b_min = r_a_blue;
        if (r_a_red >= r_a_green && r_a_red >= r_a_blue) begin
            n_b_sec = SEC_RED;
        end else if (r_a_green >= r_a_blue) begin
            n_b_sec = SEC_GREEN;
        end else begin
            n_b_sec = SEC_BLUE;
        end
    end

    always_comb begin
        n_c_d     = r_b_max - r_b_min;
        n_c_sum   = SUM_W'(r_b_max) + SUM_W'(r_b_min);
        n_c_six_d = (DIV_W'(n_c_d) << 2) + (DIV_W'(n_c_d) << 1);
        n_c_sat_den = (n_c_sum > HALF_SUM) ? (FULL_SUM - n_c_sum) : n_c_sum;
        case (r_b_sec)
            SEC_RED: begin
                if (r_b_green < r_b_blue) begin
                    n_c_hue_num = n_c_six_d - DIV_W'(r_b_blue - r_b_green);
                end else begin
                    n_c_hue_num = DIV_W'(r_b_green - r_b_blue);
                end
            end
            SEC_GREEN: n_c_hue_num = (DIV_W'(n_c_d) << 1) + DIV_W'(r_b_blue) - DIV_W'(r_b_red);
            SEC_BLUE:  n_c_hue_num = (DIV_W'(n_c_d) << 2) + DIV_W'(r_b_red) - DIV_W'(r_b_green);
            default:   n_c_hue_num = '0;
        endcase
    end

    // sum / 255 as whole part plus the remainder's bit pattern repeated
    always_comb begin
        if (r_c_lit_num >= FULL_SUM) begin
            n_l_whole = 2'd2;
            n_l_rem   = '0;
        end else if (r_c_lit_num >= HALF_SUM) begin
            n_l_whole = 2'd1;
            n_l_rem   = CH_W'(r_c_lit_num - HALF_SUM);
        end else begin
            n_l_whole = 2'd0;
            n_l_rem   = r_c_lit_num[CH_W-1:0];
        end
        n_l_rep = {4{n_l_rem}};
        n_l_q   = {n_l_whole, n_l_rep[4*CH_W-1 -: FRACTION_BITS]};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_red     <= i_red;
            r_a_green   <= i_green;
            r_a_blue    <= i_blue;
            r_b_red     <= r_a_red;
            r_b_green   <= r_a_green;
            r_b_blue    <= r_a_blue;
            r_b_max     <= n_b_max;
            r_b_min     <= n_b_min;
            r_b_sec     <= n_b_sec;
            r_c_sat_num <= DIV_W'(n_c_d);
            r_c_sat_den <= DIV_W'(n_c_sat_den);
            r_c_hue_num <= n_c_hue_num;
            r_c_hue_den <= n_c_six_d;
            r_c_lit_num <= n_c_sum;
            r_c_ach     <= (r_b_max == r_b_min);
            r_ach       <= {r_ach[QUOT_W-2:0], r_c_ach};
            r_lit[0]    <= n_l_q;
            for (int k = 1; k < QUOT_W; k++) begin
                r_lit[k] <= r_lit[k-1];
            end
        end
    end

    rgbhsl_div #(.DEN_W(DIV_W), .QUOT_W(QUOT_W)) u_div_hue (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_c_hue_num),
        .i_den  (r_c_hue_den),
        .o_quot (w_q_hue)
    );

    rgbhsl_div #(.DEN_W(DIV_W), .QUOT_W(QUOT_W)) u_div_sat (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_c_sat_num),
        .i_den  (r_c_sat_den),
        .o_quot (w_q_sat)
    );

    assign w_q_lit = r_lit[QUOT_W-1];

    always_comb begin
        w_rnd_hue = QUOT_W'(({1'b0, w_q_hue} + (QUOT_W+1)'(1)) >> 1);
        w_rnd_sat = QUOT_W'(({1'b0, w_q_sat} + (QUOT_W+1)'(1)) >> 1);
        w_rnd_lit = QUOT_W'(({1'b0, w_q_lit} + (QUOT_W+1)'(1)) >> 1);
        w_f_hue = r_ach[QUOT_W-1] ? '0 : w_rnd_hue[FRACTION_BITS-1:0];
        if (r_ach[QUOT_W-1]) begin
            w_f_sat = '0;
        end else if (w_rnd_sat > CODE_MAX) begin
            w_f_sat = CODE_MAX[FRACTION_BITS-1:0];
        end else begin
            w_f_sat = w_rnd_sat[FRACTION_BITS-1:0];
        end
        if (w_rnd_lit > CODE_MAX) begin
            w_f_lit = CODE_MAX[FRACTION_BITS-1:0];
        end else begin
            w_f_lit = w_rnd_lit[FRACTION_BITS-1:0];
        end
        n_hue = OUT_W'(w_f_hue);
        n_sat = OUT_W'(w_f_sat);
        n_lit = OUT_W'(w_f_lit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (r_o_valid && !i_ready) begin
            if (w_en && r_v[NSTG-1]) begin
                r_s_valid <= 1'b1;
            end
        end else if (r_s_valid) begin
            r_o_valid <= 1'b1;
            r_s_valid <= 1'b0;
        end else begin
            r_o_valid <= w_en && r_v[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_o_valid && !i_ready) begin
            if (w_en && r_v[NSTG-1]) begin
                r_s_hue <= n_hue;
                r_s_sat <= n_sat;
                r_s_lit <= n_lit;
            end
        end else if (r_s_valid) begin
            r_o_hue <= r_s_hue;
            r_o_sat <= r_s_sat;
            r_o_lit <= r_s_lit;
        end else begin
            r_o_hue <= n_hue;
            r_o_sat <= n_sat;
            r_o_lit <= n_lit;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_hue        = r_o_hue;
    assign o_saturation = r_o_sat;
    assign o_lightness  = r_o_lit;

endmodule

`default_nettype wire

/* hw/rtl/rgbhsl_chk.sv */
// Port-level assertions of the RGB to HSL pixel converter and their bind.
`default_nettype none

module rgbhsl_chk
    import rgbhsl_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_ready,
    input wire logic             o_valid,
    input wire logic             i_ready,
    input wire logic [OUT_W-1:0] o_hue,
    input wire logic [OUT_W-1:0] o_saturation,
    input wire logic [OUT_W-1:0] o_lightness
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    a_busy_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input blocked with no result pending");

    a_hue_needs_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (FRACTION_BITS <= OUT_W) && o_valid && (o_hue != '0) |-> (o_saturation != '0))
        else $error("chromatic hue with zero saturation");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hue) && $stable(o_saturation)
            && $stable(o_lightness))
        else $error("stalled result changed");

endmodule

bind rgb_to_hsl_pixel_core rgbhsl_chk #(.FRACTION_BITS(FRACTION_BITS)) u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_hue        (o_hue),
    .o_saturation (o_saturation),
    .o_lightness  (o_lightness)
);

`default_nettype wire

/* tb/rgb_to_hsl_pixel_core_tb.sv */
// Self-checking testbench for the RGB to HSL pixel converter core.
`default_nettype none

module rgb_to_hsl_pixel_core_tb;
    import rgbhsl_pkg::*;

    localparam int FRAC_BITS  = 16;
    localparam int TAIL_ITEMS = 150;
    localparam int RAND_ITEMS = 1200;
    localparam int LIMIT      = 200000;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [OUT_W-1:0] hue;
        logic [OUT_W-1:0] saturation;
        logic [OUT_W-1:0] lightness;
    } t_hsl;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             i_ready = 1'b0;
    logic [CH_W-1:0]  i_red   = '0;
    logic [CH_W-1:0]  i_green = '0;
    logic [CH_W-1:0]  i_blue  = '0;
    logic             o_ready;
    logic             o_valid;
    logic [OUT_W-1:0] o_hue;
    logic [OUT_W-1:0] o_saturation;
    logic [OUT_W-1:0] o_lightness;

    t_pixel pixels_to_send[$];
    t_hsl   hsl_due[$];
    int     send_gap    = 0;
    int     stall_left  = 0;
    logic   calm        = 1'b0;
    int     pixels_in   = 0;
    int     results_out = 0;
    int     bad_results = 0;
    int     cycles      = 0;

    rgb_to_hsl_pixel_core #(
        .FRACTION_BITS(FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_hue       (o_hue),
        .o_saturation(o_saturation),
        .o_lightness (o_lightness)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [63:0] quotient_q(logic [63:0] num, logic [63:0] den);
        return (num * (64'd1 << FRAC_BITS) * 2 + den) / (den * 2);
    endfunction

    function automatic logic [63:0] clamp_code(logic [63:0] v);
        logic [63:0] top;
        top = (64'd1 << FRAC_BITS) - 1;
        return (v > top) ? top : v;
    endfunction

    function automatic t_hsl rgb_to_hsl(t_pixel px);
        logic [63:0] r, g, b, mx, mn, sum, d, num, hue, sat, light;
        t_hsl res;
        r = 64'(px.red);
        g = 64'(px.green);
        b = 64'(px.blue);
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        sum   = mx + mn;
        light = clamp_code(quotient_q(sum, 64'd510));
        if (mx == mn) begin
            hue = 64'd0;
            sat = 64'd0;
        end else begin
            d = mx - mn;
            if (sum > 64'd255) begin
                sat = clamp_code(quotient_q(d, 64'd510 - sum));
            end else begin
                sat = clamp_code(quotient_q(d, sum));
            end
            if (mx == r) begin
                num = (g < b) ? 64'd6 * d - (b - g) : g - b;
            end else if (mx == g) begin
                num = 64'd2 * d + b - r;
            end else begin
                num = 64'd4 * d + r - g;
            end
            hue = quotient_q(num, 64'd6 * d) & ((64'd1 << FRAC_BITS) - 1);
        end
        res.hue        = hue[OUT_W-1:0];
        res.saturation = sat[OUT_W-1:0];
        res.lightness  = light[OUT_W-1:0];
        return res;
    endfunction

    // Sender: hold the pixel until it transfers, idle in bursts before the tail.
    always @(posedge i_clk) begin : sender
        t_pixel px;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            calm <= (pixels_to_send.size() < TAIL_ITEMS);
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                i_valid  <= 1'b0;
            end else if (pixels_to_send.size() >= TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(0, 16);
                i_valid  <= 1'b0;
            end else if (pixels_to_send.size() != 0) begin
                px = pixels_to_send.pop_front();
                i_valid <= 1'b1;
                i_red   <= px.red;
                i_green <= px.green;
                i_blue  <= px.blue;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each transfer against the oldest prediction, then log new pixels.
    always @(posedge i_clk) begin : receiver
        t_hsl want;
        t_hsl got;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_out++;
                got = '{o_hue, o_saturation, o_lightness};
                if (hsl_due.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("unexpected result: hue %h sat %h light %h",
                                 got.hue, got.saturation, got.lightness);
                end else begin
                    want = hsl_due.pop_front();
                    if (got !== want) begin
                        bad_results++;
                        if (bad_results <= 10)
                            $display("mismatch #%0d: hue %h/%h sat %h/%h light %h/%h (exp/got)",
                                     results_out, want.hue, got.hue, want.saturation,
                                     got.saturation, want.lightness, got.lightness);
                    end
                end
            end
            if (i_valid && o_ready) begin
                pixels_in++;
                hsl_due.push_back(rgb_to_hsl('{i_red, i_green, i_blue}));
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                i_ready    <= 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                stall_left <= $urandom_range(0, 16);
                i_ready    <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("rgb_to_hsl_pixel_core_tb: done, errors");
            $finish;
        end
    end

    initial begin : stimulus
        t_pixel px;
        int     m, lo, k;
        // extremes, pure primaries, ties of the largest channel, grays, near-grays, mixed colours
        pixels_to_send.push_back('{8'd0,   8'd0,   8'd0});
        pixels_to_send.push_back('{8'd255, 8'd255, 8'd255});
        pixels_to_send.push_back('{8'd128, 8'd128, 8'd128});
        pixels_to_send.push_back('{8'd255, 8'd0,   8'd0});
        pixels_to_send.push_back('{8'd0,   8'd255, 8'd0});
        pixels_to_send.push_back('{8'd0,   8'd0,   8'd255});
        pixels_to_send.push_back('{8'd255, 8'd255, 8'd0});
        pixels_to_send.push_back('{8'd255, 8'd0,   8'd255});
        pixels_to_send.push_back('{8'd0,   8'd255, 8'd255});
        pixels_to_send.push_back('{8'd255, 8'd0,   8'd1});
        pixels_to_send.push_back('{8'd255, 8'd1,   8'd0});
        pixels_to_send.push_back('{8'd1,   8'd0,   8'd0});
        pixels_to_send.push_back('{8'd0,   8'd1,   8'd1});
        pixels_to_send.push_back('{8'd255, 8'd254, 8'd254});
        pixels_to_send.push_back('{8'd254, 8'd255, 8'd255});
        pixels_to_send.push_back('{8'd128, 8'd127, 8'd127});
        pixels_to_send.push_back('{8'd127, 8'd128, 8'd127});
        pixels_to_send.push_back('{8'd129, 8'd127, 8'd127});
        pixels_to_send.push_back('{8'd127, 8'd127, 8'd129});
        pixels_to_send.push_back('{8'd170, 8'd85,  8'd0});
        pixels_to_send.push_back('{8'd10,  8'd200, 8'd100});
        pixels_to_send.push_back('{8'd90,  8'd30,  8'd240});
        for (int n = 0; n < RAND_ITEMS; n++) begin
            case ($urandom_range(0, 9))
                0: begin
                    px.red   = CH_W'($urandom_range(0, 255));
                    px.green = px.red;
                    px.blue  = px.red;
                end
                1: begin
                    m  = $urandom_range(1, 255);
                    lo = $urandom_range(0, m - 1);
                    k  = $urandom_range(0, 2);
                    px.red   = CH_W'((k == 0) ? lo : m);
                    px.green = CH_W'((k == 1) ? lo : m);
                    px.blue  = CH_W'((k == 2) ? lo : m);
                end
                2: begin
                    m = $urandom_range(0, 255);
                    px.red   = CH_W'(m ^ $urandom_range(0, 3));
                    px.green = CH_W'(m ^ $urandom_range(0, 3));
                    px.blue  = CH_W'(m ^ $urandom_range(0, 3));
                end
                default: begin
                    px.red   = CH_W'($urandom_range(0, 255));
                    px.green = CH_W'($urandom_range(0, 255));
                    px.blue  = CH_W'($urandom_range(0, 255));
                end
            endcase
            pixels_to_send.push_back(px);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pixels_to_send.size() != 0 || i_valid) @(posedge i_clk);
        while (hsl_due.size() != 0) @(posedge i_clk);
        repeat (FRAC_BITS + 10) @(posedge i_clk);

        $display("%0d pixels (grays, channel ties, near-grays, random) in, %0d out, %0d bad",
                 pixels_in, results_out, bad_results);
        if (bad_results == 0 && hsl_due.size() == 0) begin
            $display("rgb_to_hsl_pixel_core_tb: done, clean");
        end else begin
            $display("rgb_to_hsl_pixel_core_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/rgbhsl_pkg.sv
hw/rtl/rgbhsl_div.sv
hw/rtl/rgb_to_hsl_pixel_core.sv
hw/rtl/rgbhsl_chk.sv
tb/rgb_to_hsl_pixel_core_tb.sv
